// File: hw/rtl/rrof_pkg.sv
// running rank-order filter: shared payload and control types
// no dependencies; imported by the cell and the top level
`default_nettype none

package rrof_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned WinLenBits = 7;
  localparam int unsigned RankBits   = 6;

  localparam logic CfgWinLen = 1'b0;
  localparam logic CfgRank   = 1'b1;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         last_sample;
  } rrof_in_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] ranked_value;
    logic                         result_valid;
    logic                         record_end;
  } rrof_out_t;

  typedef struct packed {
    logic                         ins;
    logic                         drop;
    logic                         clr;
    logic signed [SampleBits-1:0] sample;
  } rrof_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/running_rank_order_filter.sv
// running rank-order filter top level: cell chain, fill count, output register
// depends on rrof_pkg and rrof_cell
`default_nettype none

// Sliding-window rank filter over signed 16-bit samples. A chain of MAX_WINDOW
// cells keeps the most recent samples of the configured window length sorted;
// each accepted sample is inserted, dropping the oldest entry once the window is
// full, and the entry at the configured rank (clamped to one below the window
// length) is then loaded into the output register, so no new transaction is
// taken while one is pending; a result still waiting in the output register holds
// off that load and with it the next transaction. result_valid is low and the
// value zero until the window is full. A transaction with last_sample set empties
// the window once its result is loaded. After the window length is lowered, the
// chain removes the surplus oldest entries one at a time before it takes the next
// transaction.
module running_rank_order_filter #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire rrof_pkg::rrof_in_t             in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output rrof_pkg::rrof_out_t                 out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [rrof_pkg::WinLenBits-1:0] cfg_data_i
);
  import rrof_pkg::*;

  localparam int unsigned N  = MAX_WINDOW;
  localparam int unsigned AW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned FW = $clog2(N + 1);
  localparam int unsigned CW = (FW > WinLenBits) ? FW : WinLenBits;

  logic [WinLenBits-1:0] win_len_q;
  logic [RankBits-1:0]   rank_q;
  logic [FW-1:0]         fill_q, fill_d;
  logic                  pend_q, pend_d;
  logic                  last_q;
  logic                  out_valid_q, out_valid_d;
  rrof_out_t             out_q;

  logic [CW-1:0] win_ext, rank_ext, wl_ext;
  logic [FW-1:0] wl_eff, r_eff;
  logic          accept, drop_only, out_free, load_out;
  rrof_ctrl_t    ctrl;

  logic signed [SampleBits-1:0] val_arr [N];
  logic [AW-1:0]                age_arr [N];
  logic [N-1:0]                 vld_vec, gt_vec, del_vec, del_sh, after_vec, le_vec;
  logic signed [SampleBits-1:0] pick;

  // effective window length and rank
  always_comb begin
    win_ext  = CW'(win_len_q);
    rank_ext = CW'(rank_q);
    wl_ext   = win_ext;
    if (win_ext == '0) begin
      wl_ext = CW'(1);
    end else if (win_ext > CW'(N)) begin
      wl_ext = CW'(N);
    end
    wl_eff = FW'(wl_ext);
    r_eff  = (rank_ext > wl_ext - CW'(1)) ? FW'(wl_ext - CW'(1)) : FW'(rank_ext);
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !pend_q && (fill_q <= wl_eff);
  assign accept     = in_valid_i && in_ready_o;
  assign drop_only  = !pend_q && (fill_q > wl_eff);
  assign load_out   = pend_q && out_free;

  always_comb begin
    ctrl.ins    = accept;
    ctrl.drop   = (accept && (fill_q == wl_eff)) || drop_only;
    ctrl.clr    = load_out && last_q;
    ctrl.sample = in_data_i.sample;
  end

  // oldest entry is the one aged fill-1; mark it and every place above it
  always_comb begin
    for (int k = 0; k < N; k++) begin
      del_vec[k] = ctrl.drop && vld_vec[k] && (FW'(age_arr[k]) == fill_q - FW'(1));
    end
    del_sh    = del_vec << 1;
    after_vec = ~(del_sh - N'(1));
    le_vec    = del_vec | after_vec;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic signed [SampleBits-1:0] l_val, r_val;
    logic [AW-1:0]                l_age, r_age;
    logic                         l_vld, l_gt, l_le, r_vld, r_gt;

    if (k == 0) begin : g_head
      assign l_val = '0;
      assign l_age = '0;
      assign l_vld = 1'b1;
      assign l_gt  = 1'b0;
      assign l_le  = 1'b0;
    end else begin : g_left
      assign l_val = val_arr[k-1];
      assign l_age = age_arr[k-1];
      assign l_vld = vld_vec[k-1];
      assign l_gt  = gt_vec[k-1];
      assign l_le  = le_vec[k-1];
    end

    if (k == N - 1) begin : g_tail
      assign r_val = '0;
      assign r_age = '0;
      assign r_vld = 1'b0;
      assign r_gt  = 1'b1;
    end else begin : g_right
      assign r_val = val_arr[k+1];
      assign r_age = age_arr[k+1];
      assign r_vld = vld_vec[k+1];
      assign r_gt  = gt_vec[k+1];
    end

    rrof_cell #(
      .AW(AW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .l_val_i (l_val),
      .l_age_i (l_age),
      .l_vld_i (l_vld),
      .l_gt_i  (l_gt),
      .l_le_i  (l_le),
      .r_val_i (r_val),
      .r_age_i (r_age),
      .r_vld_i (r_vld),
      .r_gt_i  (r_gt),
      .le_i    (le_vec[k]),
      .val_o   (val_arr[k]),
      .age_o   (age_arr[k]),
      .vld_o   (vld_vec[k]),
      .gt_o    (gt_vec[k])
    );
  end

  // rank select as an or-bus over the chain
  always_comb begin
    pick = '0;
    for (int k = 0; k < N; k++) begin
      if (r_eff == FW'(k)) begin
        pick = pick | val_arr[k];
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (ctrl.clr) begin
      fill_d = '0;
    end else if (ctrl.ins && !ctrl.drop) begin
      fill_d = fill_q + FW'(1);
    end else if (ctrl.drop && !ctrl.ins) begin
      fill_d = fill_q - FW'(1);
    end
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (load_out) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= WinLenBits'(5);
      rank_q      <= RankBits'(2);
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgWinLen: win_len_q <= cfg_data_i;
          CfgRank:   rank_q    <= cfg_data_i[RankBits-1:0];
          default:   ;
        endcase
      end
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= in_data_i.last_sample;
    end
    if (load_out) begin
      out_q.result_valid <= (fill_q == wl_eff);
      out_q.ranked_value <= (fill_q == wl_eff) ? pick : '0;
      out_q.record_end   <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // fill count tracks the occupied cells
  a_fill_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_vec) == int'(fill_q))
    else $error("fill count and occupied cells disagree");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(N))
    else $error("fill count beyond chain length");

  a_record_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && last_q) |=> (fill_q == '0) && (vld_vec == '0))
    else $error("window not cleared after record end");

  a_accept_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_q && !in_ready_o)
    else $error("accepted transaction not pending");

endmodule

`default_nettype wire

// File: hw/rtl/rrof_cell.sv
// running rank-order filter: one cell of the sorted chain
// holds one sample with its age; depends on rrof_pkg
`default_nettype none

module rrof_cell #(
  parameter int unsigned AW = 6
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire rrof_pkg::rrof_ctrl_t              ctrl_i,
  input  wire logic signed [rrof_pkg::SampleBits-1:0] l_val_i,
  input  wire logic [AW-1:0]                     l_age_i,
  input  wire logic                              l_vld_i,
  input  wire logic                              l_gt_i,
  input  wire logic                              l_le_i,
  input  wire logic signed [rrof_pkg::SampleBits-1:0] r_val_i,
  input  wire logic [AW-1:0]                     r_age_i,
  input  wire logic                              r_vld_i,
  input  wire logic                              r_gt_i,
  input  wire logic                              le_i,
  output logic signed [rrof_pkg::SampleBits-1:0] val_o,
  output logic [AW-1:0]                          age_o,
  output logic                                   vld_o,
  output logic                                   gt_o
);
  import rrof_pkg::*;

  logic signed [SampleBits-1:0] val_q, val_d;
  logic [AW-1:0]                age_q, age_d;
  logic                         vld_q, vld_d;
  logic signed [SampleBits-1:0] a_val, b_val;
  logic [AW-1:0]                a_age, b_age;
  logic                         a_vld, b_vld, a_gt, b_gt;

  // empty cells act as larger than any sample
  assign gt_o  = vld_q ? (val_q > ctrl_i.sample) : 1'b1;
  assign val_o = val_q;
  assign age_o = age_q;
  assign vld_o = vld_q;

  // compacted view with the dropped entry removed: this place and the one before
  always_comb begin
    a_val = le_i ? r_val_i : val_q;
    a_age = le_i ? r_age_i : age_q;
    a_vld = le_i ? r_vld_i : vld_q;
    a_gt  = le_i ? r_gt_i  : gt_o;
    b_val = l_le_i ? val_q : l_val_i;
    b_age = l_le_i ? age_q : l_age_i;
    b_vld = l_le_i ? vld_q : l_vld_i;
    b_gt  = l_le_i ? gt_o  : l_gt_i;
  end

  always_comb begin
    val_d = val_q;
    age_d = age_q;
    vld_d = vld_q;
    if (ctrl_i.clr) begin
      vld_d = 1'b0;
    end else if (ctrl_i.ins) begin
      vld_d = a_vld | b_vld;
      if (!a_gt) begin
        val_d = a_val;
        age_d = a_age + AW'(1);
      end else if (!b_gt) begin
        val_d = ctrl_i.sample;
        age_d = '0;
      end else begin
        val_d = b_val;
        age_d = b_age + AW'(1);
      end
    end else if (ctrl_i.drop) begin
      val_d = a_val;
      age_d = a_age;
      vld_d = a_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    age_q <= age_d;
  end

endmodule

`default_nettype wire

// File: test/running_rank_order_filter_tb.sv
// self-checking testbench for the running rank-order filter
// depends on rrof_pkg and running_rank_order_filter; predicts each transaction in place
`timescale 1ns / 1ps

module running_rank_order_filter_tb;
  import rrof_pkg::*;

  localparam int MaxWindow = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  rrof_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  rrof_out_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_idx = CfgWinLen;
  logic [WinLenBits-1:0] cfg_data = '0;

  rrof_in_t  pending_q[$];
  rrof_out_t ranked_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_cnt = 0;

  // shadow of the filter state
  logic signed [SampleBits-1:0] held_vals[MaxWindow];
  int unsigned held_ages[MaxWindow];
  int unsigned held_cnt = 0;
  logic [WinLenBits-1:0] win_len_reg = 7'd5;
  logic [RankBits-1:0]   rank_reg = 6'd2;

  running_rank_order_filter #(
    .MAX_WINDOW(MaxWindow)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic predict_rank(input rrof_in_t item);
    int wl;
    int rk;
    int pos;
    int oldest;
    int i;
    logic signed [SampleBits-1:0] v;
    rrof_out_t res;
    v  = item.sample;
    wl = win_len_reg;
    if (wl == 0) wl = 1;
    if (wl > MaxWindow) wl = MaxWindow;
    rk = rank_reg;
    if (rk > wl - 1) rk = wl - 1;
    // evict the oldest entries until one place is free
    while (held_cnt >= wl) begin
      oldest = 0;
      for (i = 1; i < held_cnt; i++)
        if (held_ages[i] > held_ages[oldest]) oldest = i;
      for (i = oldest; i + 1 < held_cnt; i++) begin
        held_vals[i] = held_vals[i+1];
        held_ages[i] = held_ages[i+1];
      end
      held_cnt--;
      held_vals[held_cnt] = '0;
      held_ages[held_cnt] = 0;
    end
    for (i = 0; i < held_cnt; i++) held_ages[i]++;
    // new sample goes after equal values
    pos = held_cnt;
    for (i = 0; i < held_cnt; i++)
      if (pos == held_cnt && held_vals[i] > v) pos = i;
    for (i = held_cnt; i > pos; i--) begin
      held_vals[i] = held_vals[i-1];
      held_ages[i] = held_ages[i-1];
    end
    held_vals[pos] = v;
    held_ages[pos] = 0;
    held_cnt++;
    res.result_valid = (held_cnt == wl);
    res.ranked_value = res.result_valid ? held_vals[rk] : '0;
    res.record_end   = item.last_sample;
    ranked_q.push_back(res);
    if (item.last_sample) begin
      for (i = 0; i < MaxWindow; i++) begin
        held_vals[i] = '0;
        held_ages[i] = 0;
      end
      held_cnt = 0;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) predict_rank(in_data);
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rrof_out_t exp_res;
    if (rst_ni) begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (ranked_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected transaction: value %0d valid %0b end %0b",
                     out_data.ranked_value, out_data.result_valid, out_data.record_end);
        end else begin
          exp_res = ranked_q.pop_front();
          if (out_data.ranked_value !== exp_res.ranked_value ||
              out_data.result_valid !== exp_res.result_valid ||
              out_data.record_end !== exp_res.record_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: value %0d/%0d valid %0b/%0b end %0b/%0b (exp/act)",
                       exp_res.ranked_value, out_data.ranked_value,
                       exp_res.result_valid, out_data.result_valid,
                       exp_res.record_end, out_data.record_end);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || ranked_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[WinLenBits-1:0];
    if (idx == CfgWinLen) win_len_reg = value[WinLenBits-1:0];
    else rank_reg = value[RankBits-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_item(input int sample, input bit last);
    rrof_in_t item;
    item.sample      = sample[SampleBits-1:0];
    item.last_sample = last;
    pending_q.push_back(item);
  endtask

  // random records: mostly long enough to fill the window, a few cut short
  task automatic queue_records(input int unsigned n, input int unsigned wl);
    int s;
    bit last;
    if (wl == 0) wl = 1;
    if (wl > MaxWindow) wl = MaxWindow;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0:       s = $urandom_range(0, 1) ? 32767 : -32768;
        1, 2, 3: s = $signed($urandom_range(0, 8)) - 4;
        default: s = $signed($urandom);
      endcase
      if ($urandom_range(0, 15) == 0) last = ($urandom_range(0, 3) == 0);
      else last = ($urandom_range(0, 4 * wl) == 0);
      push_item(s, last);
    end
  endtask

  initial begin
    int unsigned phase_wl[8];
    int unsigned phase_rk[8];
    int unsigned phase_n[8];
    int unsigned wl;
    int unsigned p;
    phase_wl = '{1, 64, 3, 0, 100, 64, 17, 9};
    phase_rk = '{0, 63, 63, 5, 0, 32, 8, 40};
    phase_n  = '{60, 260, 90, 60, 220, 150, 120, 100};
    for (int i = 0; i < MaxWindow; i++) begin
      held_vals[i] = '0;
      held_ages[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: window of five, median rank
    push_item(-32768, 0);
    push_item(32767, 0);
    push_item(0, 0);
    push_item(-1, 0);
    push_item(1, 0);
    push_item(7, 0);
    push_item(7, 0);
    push_item(7, 0);
    push_item(7, 0);
    push_item(32767, 0);
    push_item(-32768, 0);
    push_item(-32768, 1);
    push_item(5, 0);
    push_item(-5, 0);
    push_item(3, 0);
    push_item(3, 0);
    push_item(-3, 0);
    push_item(32767, 1);
    wait_drained();

    for (p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      if (p < 8) begin
        wl = phase_wl[p];
        write_reg(CfgWinLen, wl);
        write_reg(CfgRank, phase_rk[p]);
        queue_records(phase_n[p], wl);
      end else begin
        wl = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
        write_reg(CfgWinLen, wl);
        write_reg(CfgRank, $urandom_range(0, 63));
        queue_records(100, wl);
      end
      wait_drained();
    end

    if (mismatch_cnt == 0 && ranked_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
